// ----- rtl/suee_pkg.sv -----
`default_nettype none

package suee_pkg;

    localparam int BYTE_W = 8;
    localparam int MODE_W = 2;
    localparam int STEP_W = 2;

    // escape_mode register codes; the unused code acts as LIKE
    localparam logic [MODE_W-1:0] MODE_QUOTE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_URL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIKE  = 2'd2;

    localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h27;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_UNDER   = 8'h5F;

    localparam logic [BYTE_W-1:0] HEX_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // what the back end has to emit for one input word
    typedef enum logic [2:0] {
        K_PASS     = 3'd0,  // byte as is
        K_DUP      = 3'd1,  // quote, quote
        K_ESC      = 3'd2,  // backslash, byte
        K_PCT      = 3'd3,  // %, hi, lo
        K_PCT_LIKE = 3'd4   // backslash, %, hi, lo
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    function automatic logic [STEP_W-1:0] run_last(input t_kind kind);
        logic [STEP_W-1:0] n;
        case (kind)
            K_PASS:     n = 2'd0;
            K_DUP:      n = 2'd1;
            K_ESC:      n = 2'd1;
            K_PCT:      n = 2'd2;
            K_PCT_LIKE: n = 2'd3;
            default:    n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/suee_if.sv -----
`default_nettype none

interface suee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface suee_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/sql_url_escape_encoder_core.sv -----
`default_nettype none

// channel      dir  handshake        payload
// i_in_ch      in   valid/ready      in_byte[7:0]
// o_out_ch     out  valid/ready      out_byte[7:0], last_of_run
// i_cfg_*      in   i_cfg_we         i_cfg_wdata[1:0] -> escape_mode
//
// One output word per cycle while o_out_ch.ready is high, set by the single-byte output
// register of the back end; an input word yields 1 to 4 output words (its run length).
// Input words are taken in back to back while the command queue has room.
// An input word passes through the queue, then the output register. Reset is
// synchronous, active low; it empties the queue and sets escape_mode to quote doubling.
// Output stalls fill the queue, then drop i_in_ch.ready.

module sql_url_escape_encoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [suee_pkg::MODE_W-1:0] i_cfg_wdata,
    suee_in_if.sink                          i_in_ch,
    suee_out_if.source                       o_out_ch
);
    import suee_pkg::*;

    t_cmd push_cmd, pop_cmd;
    logic push_valid, push_ready;
    logic pop_valid, pop_ready;

    suee_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_ch      (i_in_ch),
        .o_push_cmd   (push_cmd),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready)
    );

    suee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cmd   (push_cmd),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .o_pop_cmd    (pop_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready)
    );

    suee_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_cmd   (pop_cmd),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .o_out_ch    (o_out_ch)
    );

endmodule

`default_nettype wire

// ----- rtl/suee_front.sv -----
`default_nettype none

module suee_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [suee_pkg::MODE_W-1:0] i_cfg_wdata,
    suee_in_if.sink                         i_in_ch,
    output suee_pkg::t_cmd                  o_push_cmd,
    output logic                            o_push_valid,
    input  wire logic                       i_push_ready
);
    import suee_pkg::*;

    logic [MODE_W-1:0] r_escape_mode;
    logic              url_safe;
    logic              like;
    logic [BYTE_W-1:0] b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_mode <= MODE_QUOTE;
        end else if (i_cfg_we) begin
            r_escape_mode <= i_cfg_wdata;
        end
    end

    assign b    = i_in_ch.in_byte;
    assign like = r_escape_mode[1];

    always_comb begin
        url_safe = b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                             8'h2E, 8'h2D, 8'h5F, 8'h2F, 8'h28, 8'h29, 8'h7E,
                             8'h2C, 8'h26, 8'h5B, 8'h5D, 8'h21, 8'h40, 8'h24};
    end

    always_comb begin
        o_push_cmd.data = b;
        if (r_escape_mode == MODE_QUOTE) begin
            o_push_cmd.kind = (b == CH_QUOTE) ? K_DUP : K_PASS;
        end else if (like && b == CH_UNDER) begin
            o_push_cmd.kind = K_ESC;
        end else if (url_safe) begin
            o_push_cmd.kind = K_PASS;
        end else begin
            o_push_cmd.kind = like ? K_PCT_LIKE : K_PCT;
        end
    end

    assign o_push_valid   = i_in_ch.valid;
    assign i_in_ch.ready  = i_push_ready;

endmodule

`default_nettype wire

// ----- rtl/suee_queue.sv -----
`default_nettype none

module suee_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire suee_pkg::t_cmd i_push_cmd,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    output suee_pkg::t_cmd      o_pop_cmd,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready
);
    import suee_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push, pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/suee_back.sv -----
`default_nettype none

module suee_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire suee_pkg::t_cmd i_pop_cmd,
    input  wire logic           i_pop_valid,
    output logic                o_pop_ready,
    suee_out_if.source          o_out_ch
);
    import suee_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    logic              load;
    logic              last;
    logic [BYTE_W-1:0] n_byte;
    logic [BYTE_W-1:0] hex_hi, hex_lo;

    assign load   = !r_valid || o_out_ch.ready;
    assign last   = (r_step == run_last(i_pop_cmd.kind));
    assign hex_hi = HEX_UPPER[i_pop_cmd.data[7:4]];
    assign hex_lo = HEX_UPPER[i_pop_cmd.data[3:0]];

    // head of queue stays put until the last word of its run is loaded into the output register
    assign o_pop_ready = load && last;

    always_comb begin
        n_byte = i_pop_cmd.data;
        case (i_pop_cmd.kind)
            K_PASS, K_DUP: n_byte = i_pop_cmd.data;
            K_ESC:         n_byte = (r_step == 2'd0) ? CH_BSLASH : i_pop_cmd.data;
            K_PCT: begin
                case (r_step)
                    2'd0:    n_byte = CH_PERCENT;
                    2'd1:    n_byte = hex_hi;
                    default: n_byte = hex_lo;
                endcase
            end
            K_PCT_LIKE: begin
                case (r_step)
                    2'd0:    n_byte = CH_BSLASH;
                    2'd1:    n_byte = CH_PERCENT;
                    2'd2:    n_byte = hex_hi;
                    default: n_byte = hex_lo;
                endcase
            end
            default:       n_byte = i_pop_cmd.data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (load) begin
            r_valid <= i_pop_valid;
            if (i_pop_valid) begin
                r_step <= last ? '0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_pop_valid) begin
            r_byte <= n_byte;
            r_last <= last;
        end
    end

    assign o_out_ch.valid       = r_valid;
    assign o_out_ch.out_byte    = r_byte;
    assign o_out_ch.last_of_run = r_last;

    // mid-run the head word must still be in the queue
    a_mid_run_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != '0 |-> i_pop_valid)
        else $error("step counter mid-run with empty queue");

    a_step_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop_valid |-> r_step <= run_last(i_pop_cmd.kind))
        else $error("step counter past end of run");

    a_step_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && i_pop_valid && !last |=> r_step == $past(r_step) + 1'b1)
        else $error("step counter failed to advance");

    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && i_pop_valid && last |=> r_valid && r_last && r_step == '0)
        else $error("run end not marked");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import suee_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;   // unused code, acts as LIKE
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 40;    // words in before the long output hold
    localparam int HOLD_LEN    = 100;
    localparam int PHASE_WORDS = 45;
    localparam int N_DIRECTED  = 22;

    // escaped run of one input word, first byte in the top bits
    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] bytes;
    } t_run;

    // len 0 in want: take the expectation from the predictor
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [7:0]        data;
        t_run              want;
    } t_row;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_word;

    localparam t_row DIRECTED [N_DIRECTED] = '{
        {MODE_QUOTE, 8'h27, 3'd2, 32'h2727_0000},
        {MODE_QUOTE, 8'h00, 3'd1, 32'h0000_0000},
        {MODE_QUOTE, 8'hFF, 3'd1, 32'hFF00_0000},
        {MODE_QUOTE, 8'h41, 3'd0, 32'h0},
        {MODE_QUOTE, 8'h5F, 3'd0, 32'h0},
        {MODE_URL,   8'h00, 3'd3, 32'h2530_3000},
        {MODE_URL,   8'hFF, 3'd3, 32'h2546_4600},
        {MODE_URL,   8'h7A, 3'd1, 32'h7A00_0000},
        {MODE_URL,   8'h5F, 3'd1, 32'h5F00_0000},
        {MODE_URL,   8'h27, 3'd0, 32'h0},
        {MODE_URL,   8'h25, 3'd0, 32'h0},
        {MODE_URL,   8'h7E, 3'd0, 32'h0},
        {MODE_URL,   8'h40, 3'd0, 32'h0},
        {MODE_URL,   8'h24, 3'd0, 32'h0},
        {MODE_URL,   8'h20, 3'd0, 32'h0},
        {MODE_LIKE,  8'h5F, 3'd2, 32'h5C5F_0000},
        {MODE_LIKE,  8'h00, 3'd4, 32'h5C25_3030},
        {MODE_LIKE,  8'hFF, 3'd4, 32'h5C25_4646},
        {MODE_LIKE,  8'h39, 3'd0, 32'h0},
        {MODE_LIKE,  8'h5C, 3'd0, 32'h0},
        {MODE_SPARE, 8'h5F, 3'd2, 32'h5C5F_0000},
        {MODE_SPARE, 8'h80, 3'd0, 32'h0}
    };

    localparam logic [MODE_W-1:0] PHASE_MODES [8] = '{
        MODE_URL, MODE_LIKE, MODE_QUOTE, MODE_SPARE,
        MODE_LIKE, MODE_URL, MODE_QUOTE, MODE_LIKE
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [MODE_W-1:0] i_cfg_wdata;

    suee_in_if  in_ch ();
    suee_out_if out_ch ();

    sql_url_escape_encoder_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    t_word             escaped_q[$];
    logic [MODE_W-1:0] cur_mode;
    int                errors    = 0;
    int                words_in  = 0;
    int                burst_left = 0;
    int                cycles    = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + nib : 8'h37 + nib;
    endfunction

    function automatic bit url_plain(input logic [7:0] b);
        if (b >= "a" && b <= "z") return 1'b1;
        if (b >= "A" && b <= "Z") return 1'b1;
        if (b >= "0" && b <= "9") return 1'b1;
        case (b)
            ".", "-", "_", "/", "(", ")", "~", ",", "&", "[", "]", "!", "@", "$":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic t_run escape_run(input logic [MODE_W-1:0] mode, input logic [7:0] b);
        t_run r;
        bit   like;
        r    = '0;
        like = mode[1];   // LIKE and the spare code
        if (mode == MODE_QUOTE) begin
            if (b == CH_QUOTE) begin
                r.len   = 3'd2;
                r.bytes = {CH_QUOTE, CH_QUOTE, 16'h0};
            end else begin
                r.len   = 3'd1;
                r.bytes = {b, 24'h0};
            end
        end else if (like && b == CH_UNDER) begin
            r.len   = 3'd2;
            r.bytes = {CH_BSLASH, b, 16'h0};
        end else if (url_plain(b)) begin
            r.len   = 3'd1;
            r.bytes = {b, 24'h0};
        end else if (like) begin
            r.len   = 3'd4;
            r.bytes = {CH_BSLASH, CH_PERCENT, hex_char(b[7:4]), hex_char(b[3:0])};
        end else begin
            r.len   = 3'd3;
            r.bytes = {CH_PERCENT, hex_char(b[7:4]), hex_char(b[3:0]), 8'h0};
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        string punct;
        punct = ".-_/()~,&[]!@$";
        case ($urandom_range(0, 9))
            5:       return CH_QUOTE;
            6:       return CH_UNDER;
            7:       return punct[$urandom_range(0, punct.len() - 1)];
            8:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            9:       return $urandom_range(0, 1) ? 8'h61 + 8'($urandom_range(0, 25))
                                                 : 8'h30 + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    task automatic send_word(input logic [7:0] b, input t_run want);
        int k;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        for (k = 0; k < want.len; k++)
            escaped_q.push_back({want.bytes[31 - 8 * k -: 8], k == want.len - 1});
        words_in++;
        burst_left--;
        if (burst_left == 0)
            in_ch.valid <= 1'b0;
    endtask

    task automatic end_burst();
        if (burst_left != 0) begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic drain();
        while (escaped_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        cur_mode     = m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // output side: random stall pattern plus one long hold to back up the queue
    initial begin
        int  hold_left;
        int  pat_left;
        bit  pat_ready;
        bit  hold_done;
        hold_left = 0;
        pat_left  = 0;
        pat_ready = 1'b0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (!hold_done && words_in >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                out_ch.ready <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_ready = ~pat_ready;
                    if (pat_ready)
                        pat_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
                    else
                        pat_left = $urandom_range(1, 8);
                end
                pat_left--;
                out_ch.ready <= pat_ready;
            end
        end
    end

    always @(posedge i_clk) begin
        t_word exp_w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (escaped_q.size() == 0) begin
                flag_mismatch("unexpected word", out_ch.out_byte, 8'h00);
            end else begin
                exp_w = escaped_q.pop_front();
                if (out_ch.out_byte !== exp_w.data)
                    flag_mismatch("out_byte", out_ch.out_byte, exp_w.data);
                if (out_ch.last_of_run !== exp_w.last)
                    flag_mismatch("last_of_run", {7'h0, out_ch.last_of_run},
                                  {7'h0, exp_w.last});
            end
        end
    end

    initial begin
        int   i;
        int   p;
        t_run want;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= MODE_QUOTE;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        cur_mode       = MODE_QUOTE;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].mode != cur_mode) begin
                end_burst();
                drain();
                write_mode(DIRECTED[i].mode);
            end
            want = (DIRECTED[i].want.len != 0) ? DIRECTED[i].want
                                                : escape_run(cur_mode, DIRECTED[i].data);
            send_word(DIRECTED[i].data, want);
        end

        for (p = 0; p < 8; p++) begin
            end_burst();
            drain();
            write_mode(PHASE_MODES[p]);
            for (i = 0; i < PHASE_WORDS; i++) begin
                logic [7:0] b;
                b = pick_byte();
                send_word(b, escape_run(cur_mode, b));
            end
        end

        end_burst();
        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
